### hdl/lpad_pkg.sv
// ---------------------------------------------------------------------------
// lpad_pkg: shared types and constants of the length-prefixed deframer
// Result codes, register indexes, reset values and the Adler-32 byte update.
// ---------------------------------------------------------------------------
`default_nettype none

package lpad_pkg;

  localparam int unsigned LEN_W      = 31;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  localparam logic [LEN_W-1:0] MIN_LEN_RST = 31'd10;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 31'd67108864;

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_MIN = 1'b0;
  localparam logic CFG_IDX_MAX = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_BODY    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // verdict codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_SUM  = 2'd2;
  localparam logic [1:0] ST_BAD_NAME = 2'd3;

  // length limits handed from the register block to the parser
  typedef struct packed {
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
  } lpad_cfg_t;

  // Adler-32 update for one byte: returns {sum_high, sum_low}
  function automatic logic [31:0] lpad_adler_step(input logic [15:0] lo,
                                                  input logic [15:0] hi,
                                                  input logic [7:0]  b);
    logic [16:0] lo_sum;
    logic [15:0] lo_new;
    logic [16:0] hi_sum;
    logic [15:0] hi_new;
    lo_sum = {1'b0, lo} + {9'd0, b};
    if (lo_sum >= ADLER_MOD) begin
      lo_sum = lo_sum - ADLER_MOD;
    end
    lo_new = lo_sum[15:0];
    hi_sum = {1'b0, hi} + {1'b0, lo_new};
    if (hi_sum >= ADLER_MOD) begin
      hi_sum = hi_sum - ADLER_MOD;
    end
    hi_new = hi_sum[15:0];
    return {hi_new, lo_new};
  endfunction

endpackage

`default_nettype wire

### hdl/lpad_cfg.sv
// ---------------------------------------------------------------------------
// lpad_cfg: frame length limit registers
// APB-style write and read of the minimum and maximum frame length.
// ---------------------------------------------------------------------------
`default_nettype none

module lpad_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [lpad_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire  [lpad_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [lpad_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output lpad_pkg::lpad_cfg_t          cfg_o
);
  import lpad_pkg::*;

  logic [LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0] max_len_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // write the addressed limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == CFG_IDX_MIN) begin
        min_len_r <= cfg_pwdata[LEN_W-1:0];
      end else begin
        max_len_r <= cfg_pwdata[LEN_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (cfg_paddr[2] == CFG_IDX_MAX) begin
      cfg_prdata = {1'b0, max_len_r};
    end else begin
      cfg_prdata = {1'b0, min_len_r};
    end
  end

  assign cfg_o.min_len = min_len_r;
  assign cfg_o.max_len = max_len_r;

endmodule

`default_nettype wire

### hdl/lpad_frame.sv
// ---------------------------------------------------------------------------
// lpad_frame: frame parser with running Adler-32 and result register
// Walks prefix, name length, payload and trailer one word per cycle while in_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module lpad_frame (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire lpad_pkg::lpad_cfg_t cfg_i,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_rx_byte,
  input  wire                   in_clear,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output logic [1:0]            out_status,
  output logic                  out_frame_end
);
  import lpad_pkg::*;

  typedef enum logic [4:0] {
    PH_PREFIX  = 5'b00001,
    PH_NAMELEN = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_TRAILER = 5'b01000,
    PH_BLOCKED = 5'b10000
  } phase_t;

  phase_t           phase_r,   phase_nxt;
  logic [LEN_W-1:0] cnt_r,     cnt_nxt;
  logic [LEN_W-1:0] pay_len_r, pay_len_nxt;
  logic [31:0]      name_r,    name_nxt;
  logic             name_ok_r, name_ok_nxt;
  logic [15:0]      sum_lo_r,  sum_lo_nxt;
  logic [15:0]      sum_hi_r,  sum_hi_nxt;
  logic [23:0]      field_r,   field_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r;
  logic [7:0]       byte_r;
  logic [1:0]       status_r;
  logic             end_r;

  logic             acc;
  logic             res_vld;
  logic [1:0]       res_kind;
  logic [1:0]       res_status;
  logic             res_end;
  logic [7:0]       res_byte;
  logic [31:0]      word_new;
  logic [31:0]      adler_new;
  logic [LEN_W-1:0] cnt_inc;
  logic             len_bad;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign word_new  = {field_r, in_rx_byte};
  assign adler_new = lpad_adler_step(sum_lo_r, sum_hi_r, in_rx_byte);
  assign cnt_inc   = cnt_r + 1'b1;
  assign len_bad   = word_new[31] || (word_new[LEN_W-1:0] < 31'd8) ||
                     (word_new[LEN_W-1:0] < cfg_i.min_len) ||
                     (word_new[LEN_W-1:0] > cfg_i.max_len);

  // advance the parser on each accepted word
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    pay_len_nxt = pay_len_r;
    name_nxt    = name_r;
    name_ok_nxt = name_ok_r;
    sum_lo_nxt  = sum_lo_r;
    sum_hi_nxt  = sum_hi_r;
    field_nxt   = field_r;
    res_vld     = 1'b0;
    res_kind    = KIND_VERDICT;
    res_status  = ST_OK;
    res_end     = 1'b0;
    res_byte    = 8'd0;
    if (acc) begin
      if (in_clear || (phase_r == PH_TRAILER && cnt_r[1:0] == 2'd3)) begin
        // restart at a length prefix
        phase_nxt   = PH_PREFIX;
        cnt_nxt     = '0;
        pay_len_nxt = '0;
        name_nxt    = '0;
        name_ok_nxt = 1'b0;
        sum_lo_nxt  = 16'd1;
        sum_hi_nxt  = 16'd0;
        field_nxt   = '0;
      end
      if (!in_clear) begin
        case (phase_r)
          PH_PREFIX: begin
            field_nxt = word_new[23:0];
            cnt_nxt   = cnt_inc;
            if (cnt_r[1:0] == 2'd3) begin
              cnt_nxt = '0;
              if (len_bad) begin
                phase_nxt  = PH_BLOCKED;
                res_vld    = 1'b1;
                res_status = ST_BAD_LEN;
              end else begin
                phase_nxt   = PH_NAMELEN;
                pay_len_nxt = word_new[LEN_W-1:0] - 31'd8;
              end
            end
          end
          PH_NAMELEN: begin
            sum_lo_nxt = adler_new[15:0];
            sum_hi_nxt = adler_new[31:16];
            name_nxt   = {name_r[23:0], in_rx_byte};
            cnt_nxt    = cnt_inc;
            if (cnt_r[1:0] == 2'd3) begin
              cnt_nxt     = '0;
              name_ok_nxt = (name_nxt >= 32'd2) && (name_nxt <= {1'b0, pay_len_r});
              phase_nxt   = (pay_len_r == '0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            sum_lo_nxt = adler_new[15:0];
            sum_hi_nxt = adler_new[31:16];
            cnt_nxt    = cnt_inc;
            if (cnt_inc >= pay_len_r) begin
              cnt_nxt   = '0;
              phase_nxt = PH_TRAILER;
            end
            res_vld  = 1'b1;
            res_byte = in_rx_byte;
            res_kind = (name_ok_r && ({1'b0, cnt_r} < name_r)) ? KIND_NAME : KIND_BODY;
          end
          PH_TRAILER: begin
            if (cnt_r[1:0] != 2'd3) begin
              field_nxt = word_new[23:0];
              cnt_nxt   = cnt_inc;
            end else begin
              res_vld = 1'b1;
              res_end = 1'b1;
              if (word_new != {sum_hi_r, sum_lo_r}) begin
                res_status = ST_BAD_SUM;
              end else if (!name_ok_r) begin
                res_status = ST_BAD_NAME;
              end else begin
                res_status = ST_OK;
              end
            end
          end
          PH_BLOCKED: begin
            // drop every word until a clear
          end
          default: begin
            phase_nxt = PH_PREFIX;
          end
        endcase
      end
    end
  end

  // hold the result until taken
  always_comb begin
    if (res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PREFIX;
      cnt_r       <= '0;
      pay_len_r   <= '0;
      name_r      <= '0;
      name_ok_r   <= 1'b0;
      sum_lo_r    <= 16'd1;
      sum_hi_r    <= 16'd0;
      field_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      pay_len_r   <= pay_len_nxt;
      name_r      <= name_nxt;
      name_ok_r   <= name_ok_nxt;
      sum_lo_r    <= sum_lo_nxt;
      sum_hi_r    <= sum_hi_nxt;
      field_r     <= field_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the result payload
  always_ff @(posedge clk) begin
    if (res_vld) begin
      kind_r   <= res_kind;
      byte_r   <= res_byte;
      status_r <= res_status;
      end_r    <= res_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_byte      = byte_r;
  assign out_status    = status_r;
  assign out_frame_end = end_r;

  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, sum_lo_r} < ADLER_MOD) && ({1'b0, sum_hi_r} < ADLER_MOD))
    else $error("adler sums not reduced");

  a_bad_len_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && (res_status == ST_BAD_LEN) && !res_end |=> phase_r == PH_BLOCKED)
    else $error("bad length did not block");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BLOCKED) && !(acc && in_clear) |=> phase_r == PH_BLOCKED)
    else $error("left blocked state without clear");

  a_end_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res_end |-> (res_kind == KIND_VERDICT) && (phase_nxt == PH_PREFIX))
    else $error("frame end without verdict and restart");

endmodule

`default_nettype wire

### hdl/length_prefixed_adler_deframer_unit.sv
// A result is registered and shows on the out_ ports in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the combinational Adler-32 update bounds the clock.
// in_ready stays high while the result register is empty or being drained.
// Reset: synchronous, active low; parser waits for a length prefix, limits
// return to 10 and 67108864.
// ---------------------------------------------------------------------------
// length_prefixed_adler_deframer_unit: byte-stream frame splitter
// Splits length-prefixed frames, passes name and body bytes on and checks
// the Adler-32 trailer of each frame.
// ---------------------------------------------------------------------------
`default_nettype none

module length_prefixed_adler_deframer_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   in_rx_byte,
  input  wire                          in_clear,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_byte,
  output logic [1:0]                   out_status,
  output logic                         out_frame_end,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [lpad_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire  [lpad_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [lpad_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import lpad_pkg::*;

  lpad_cfg_t cfg;

  // length limit registers
  lpad_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // parser and result register
  lpad_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_i         (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_clear      (in_clear),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .out_status    (out_status),
    .out_frame_end (out_frame_end)
  );

endmodule

`default_nettype wire

### verif/tb_length_prefixed_adler_deframer_unit.sv
// ---------------------------------------------------------------------------
// tb_length_prefixed_adler_deframer_unit: self-checking bench of the deframer
// Feeds length-prefixed frames, broken frames, noise and clears one word at a
// time, predicts every name, body and verdict word and compares each result
// word field by field. Length limits are reprogrammed between traffic phases
// and read back, and both channels idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_length_prefixed_adler_deframer_unit;
  import lpad_pkg::*;

  typedef enum logic [1:0] {AWAIT_LEN, AWAIT_NAME_LEN, IN_PAYLOAD, IN_TRAILER} parse_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       frame_end;
  } out_word_t;

  // Tracks the parser state and the length limits, and holds the result
  // words still awaited from the block.
  class deframe_tracker;
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
    parse_phase_t     phase;
    logic [31:0]      count;
    logic [31:0]      frame_len;
    logic [31:0]      name_len;
    logic [31:0]      trailer;
    logic [15:0]      sum_lo;
    logic [15:0]      sum_hi;
    bit               blocked;
    out_word_t        awaited[$];
    int unsigned      errors;
    int unsigned      live_words;
    int unsigned      name_words;
    int unsigned      body_words;
    int unsigned      verdicts[4];

    function new();
      min_len = MIN_LEN_RST;
      max_len = MAX_LEN_RST;
      blocked = 1'b0;
      restart();
    endfunction

    function void restart();
      phase     = AWAIT_LEN;
      count     = '0;
      frame_len = '0;
      name_len  = '0;
      trailer   = '0;
      sum_lo    = 16'd1;
      sum_hi    = 16'd0;
    endfunction

    function void set_limit(logic idx, logic [31:0] value);
      if (idx == CFG_IDX_MIN) begin
        min_len = value[LEN_W-1:0];
      end else begin
        max_len = value[LEN_W-1:0];
      end
    endfunction

    function void add_to_sum(logic [7:0] b);
      logic [16:0] acc;
      acc = {1'b0, sum_lo} + {9'd0, b};
      if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
      sum_lo = acc[15:0];
      acc = {1'b0, sum_hi} + {1'b0, sum_lo};
      if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
      sum_hi = acc[15:0];
    endfunction

    function bit name_fits();
      return name_len >= 32'd2 && name_len <= frame_len - 32'd8;
    endfunction

    function void await_word(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
                             logic frame_end);
      awaited.push_back('{kind, data, status, frame_end});
      if (kind == KIND_NAME) name_words++;
      else if (kind == KIND_BODY) body_words++;
      else verdicts[status]++;
    endfunction

    // Advance the parser by one accepted input word.
    function void note_word(logic [7:0] b, logic clr);
      logic [1:0] kind;
      logic [1:0] verdict;
      if (clr) begin
        blocked = 1'b0;
        restart();
        live_words++;
        return;
      end
      // drop everything after a rejected length until a clear
      if (blocked) return;
      live_words++;
      case (phase)
        AWAIT_LEN: begin
          frame_len = {frame_len[23:0], b};
          count++;
          if (count == 32'd4) begin
            count = '0;
            if (frame_len[31] || frame_len < 32'd8 || frame_len < {1'b0, min_len} ||
                frame_len > {1'b0, max_len}) begin
              blocked = 1'b1;
              await_word(KIND_VERDICT, 8'h00, ST_BAD_LEN, 1'b0);
            end else begin
              phase  = AWAIT_NAME_LEN;
              sum_lo = 16'd1;
              sum_hi = 16'd0;
            end
          end
        end
        AWAIT_NAME_LEN: begin
          add_to_sum(b);
          name_len = {name_len[23:0], b};
          count++;
          if (count == 32'd4) begin
            count = '0;
            phase = (frame_len == 32'd8) ? IN_TRAILER : IN_PAYLOAD;
          end
        end
        IN_PAYLOAD: begin
          kind = (name_fits() && count < name_len) ? KIND_NAME : KIND_BODY;
          add_to_sum(b);
          count++;
          if (count >= frame_len - 32'd8) begin
            count = '0;
            phase = IN_TRAILER;
          end
          await_word(kind, b, ST_OK, 1'b0);
        end
        IN_TRAILER: begin
          trailer = {trailer[23:0], b};
          count++;
          if (count == 32'd4) begin
            // checksum outranks the name length
            if (trailer != {sum_hi, sum_lo}) verdict = ST_BAD_SUM;
            else if (!name_fits()) verdict = ST_BAD_NAME;
            else verdict = ST_OK;
            restart();
            await_word(KIND_VERDICT, 8'h00, verdict, 1'b1);
          end
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest awaited one.
    function void check_word(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        $error("result word with nothing awaited: kind %0d, byte %02h, status %0d",
               got.kind, got.data, got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, got.data);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_rx_byte = '0;
  logic                in_clear = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_byte;
  logic [1:0]          out_status;
  logic                out_frame_end;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  int unsigned         in_idle_pct = 0;
  int unsigned         out_idle_pct = 0;
  int unsigned         out_hold_left = 0;
  int unsigned         gen_lo = 10;
  int unsigned         gen_hi = 80;

  deframe_tracker      tracker = new();

  length_prefixed_adler_deframer_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_clear      (in_clear),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .out_status    (out_status),
    .out_frame_end (out_frame_end),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adler-32 over a byte sequence, for building trailers
  function automatic logic [31:0] adler_sum(input logic [7:0] data[$]);
    int unsigned lo;
    int unsigned hi;
    lo = 1;
    hi = 0;
    foreach (data[i]) begin
      lo = (lo + data[i]) % 65521;
      hi = (hi + lo) % 65521;
    end
    return {hi[15:0], lo[15:0]};
  endfunction

  // Offer one input word, idling first at random, and hold it until taken.
  task automatic send_word(input logic [7:0] b, input logic clr);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_clear   <= clr;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(b, clr);
  endtask

  // Stop offering and wait for every awaited result word.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  task automatic apb_xfer(input logic idx, input bit wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_limit(input logic idx);
    logic [31:0]      rd;
    logic [LEN_W-1:0] want;
    apb_xfer(idx, 1'b0, 32'd0, rd);
    want = (idx == CFG_IDX_MIN) ? tracker.min_len : tracker.max_len;
    if (rd[LEN_W-1:0] !== want) begin
      $error("%s: expected %0d, got %0d",
             (idx == CFG_IDX_MIN) ? "min_frame_length" : "max_frame_length",
             want, rd[LEN_W-1:0]);
      tracker.errors++;
    end
  endtask

  // Write a limit once the block has gone quiet, then read it back.
  task automatic program_limit(input logic idx, input logic [31:0] value);
    logic [31:0] rd;
    pause_until_drained();
    repeat (4) @(posedge clk);
    apb_xfer(idx, 1'b1, value, rd);
    tracker.set_limit(idx, value);
    verify_limit(idx);
  endtask

  // A length prefix meant to be rejected, some ignored words, then a clear.
  task automatic send_bad_prefix(input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_word(len[31-8*i -: 8], 1'b0);
    repeat ($urandom_range(3)) send_word(8'($urandom), 1'b0);
    send_word(8'($urandom), 1'b1);
  endtask

  // Build one frame; a non-zero cut shorter than the frame sends only that many words, then a clear.
  task automatic send_frame(input logic [31:0] len, input logic [31:0] nlen,
                            input bit bad_sum, input int unsigned cut);
    logic [7:0]  covered[$];
    logic [7:0]  stream[$];
    logic [31:0] sum;
    bit          ff_fill;
    int unsigned i;
    // all-ones payloads push both sums through the modulus
    ff_fill = ($urandom_range(19) == 0);
    for (i = 0; i < 4; i++) covered.push_back(nlen[31-8*i -: 8]);
    for (i = 0; i < len - 8; i++) covered.push_back(ff_fill ? 8'hFF : 8'($urandom));
    sum = adler_sum(covered);
    if (bad_sum) sum = sum ^ (32'd1 << $urandom_range(31));
    for (i = 0; i < 4; i++) stream.push_back(len[31-8*i -: 8]);
    stream = {stream, covered};
    for (i = 0; i < 4; i++) stream.push_back(sum[31-8*i -: 8]);
    if (cut == 0 || cut > stream.size()) cut = stream.size();
    for (i = 0; i < cut; i++) send_word(stream[i], 1'b0);
    if (cut < stream.size()) send_word(8'($urandom), 1'b1);
  endtask

  // Mostly well-formed frames, with rejects, cut frames, noise and clears.
  task automatic random_traffic(input int unsigned target);
    int unsigned pick;
    int unsigned len;
    int unsigned room;
    logic [31:0] nlen;
    logic [31:0] bad_len;
    while (tracker.live_words < target) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 3) len = $urandom_range(gen_hi, gen_lo);
      else len = $urandom_range(gen_lo, (gen_hi < gen_lo + 60) ? gen_hi : gen_lo + 60);
      room = len - 8;
      if ($urandom_range(99) < 80 && room >= 2) begin
        nlen = $urandom_range(room, 2);
      end else begin
        case ($urandom_range(5))
          0:       nlen = 32'd0;
          1:       nlen = 32'd1;
          2:       nlen = room + 1;
          3:       nlen = room;
          4:       nlen = $urandom;
          default: nlen = 32'hFFFF_FFFF;
        endcase
      end
      if (pick < 70) begin
        send_frame(len, nlen, $urandom_range(9) == 0, 0);
      end else if (pick < 80) begin
        case ($urandom_range(3))
          0:       bad_len = {1'b0, tracker.min_len} - 32'd1;
          1:       bad_len = {1'b0, tracker.max_len} + 32'd1;
          2:       bad_len = 32'h8000_0000 | $urandom;
          default: bad_len = $urandom_range(7);
        endcase
        send_bad_prefix(bad_len);
      end else if (pick < 88) begin
        send_frame(len, nlen, 1'b0, $urandom_range(len + 3, 1));
      end else if (pick < 95) begin
        repeat ($urandom_range(8, 1)) send_word(8'($urandom), 1'b0);
        send_word(8'($urandom), 1'b1);
      end else begin
        send_word(8'($urandom), 1'b1);
      end
      if ($urandom_range(49) == 0) pause_until_drained();
    end
  endtask

  // Result side: check accepted words, stall at random or for a long hold.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_word({out_kind, out_byte, out_status, out_frame_end});
      end
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    verify_limit(CFG_IDX_MIN);
    verify_limit(CFG_IDX_MAX);
    in_idle_pct  = 24;
    out_idle_pct = 78;

    // directed: length under the reset minimum
    send_bad_prefix(32'd9);
    program_limit(CFG_IDX_MIN, 32'd8);
    program_limit(CFG_IDX_MAX, 32'd2000);
    // empty payload, then name length at both bounds
    send_frame(32'd8, 32'd5, 1'b0, 0);
    send_frame(32'd12, 32'd2, 1'b0, 0);
    send_frame(32'd11, 32'd3, 1'b0, 0);
    // name length too short and too long
    send_frame(32'd11, 32'd1, 1'b0, 0);
    send_frame(32'd11, 32'd4, 1'b0, 0);
    // bad checksum alone, then together with a bad name length
    send_frame(32'd14, 32'd3, 1'b1, 0);
    send_frame(32'd10, 32'hFFFF_FFFF, 1'b1, 0);
    // top bit set, under eight, over the maximum
    send_bad_prefix(32'h8000_000C);
    send_bad_prefix(32'd7);
    send_bad_prefix(32'd2001);
    send_word(8'hA5, 1'b1);
    // minimum above maximum rejects every length
    program_limit(CFG_IDX_MIN, 32'd100);
    program_limit(CFG_IDX_MAX, 32'd50);
    send_bad_prefix(32'd75);

    // reset limits, receiver mostly stalled
    program_limit(CFG_IDX_MIN, MIN_LEN_RST);
    program_limit(CFG_IDX_MAX, MAX_LEN_RST);
    gen_lo = 10;
    gen_hi = 80;
    random_traffic(tracker.live_words + 600);

    // widest limits, sender mostly idle
    program_limit(CFG_IDX_MIN, 32'd8);
    program_limit(CFG_IDX_MAX, 32'hFFFF_FFFF);
    in_idle_pct  = 78;
    out_idle_pct = 24;
    gen_lo = 8;
    gen_hi = 700;
    random_traffic(tracker.live_words + 600);

    // narrow limits, no idling, one long receiver hold
    program_limit(CFG_IDX_MIN, 32'h8000_000C);
    program_limit(CFG_IDX_MAX, 32'd40);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    gen_lo = 12;
    gen_hi = 40;
    out_hold_left = 400;
    random_traffic(tracker.live_words + 600);

    pause_until_drained();
    repeat (5) @(posedge clk);
    $display("covered %0d live words: %0d name and %0d body bytes passed on",
             tracker.live_words, tracker.name_words, tracker.body_words);
    $display("verdicts: %0d ok, %0d bad length, %0d bad checksum, %0d bad name length",
             tracker.verdicts[ST_OK], tracker.verdicts[ST_BAD_LEN],
             tracker.verdicts[ST_BAD_SUM], tracker.verdicts[ST_BAD_NAME]);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
